>>> src/rss_pkg.sv
// ----------------------------------------------------------------------------
// Route scenario sequencer package
// Shared types, codes and constants for the route scenario sequencer.
// ----------------------------------------------------------------------------
package rss_pkg;

  // Default number of route table entries.
  localparam int unsigned RSS_ROUTE_DEPTH = 16;

  // Reset values of the debounce margins.
  localparam logic [3:0] RSS_MARGIN_RESET = 4'd6;

  // Request types carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_SHAPE   = 2'd1,
    REQ_TURN    = 2'd2,
    REQ_EXTSTOP = 2'd3
  } rss_req_e;

  // Result kinds carried on the output tuser.
  typedef enum logic [1:0] {
    OK_STATUS = 2'd0,
    OK_STOP   = 2'd1,
    OK_ROTATE = 2'd2
  } rss_okind_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_MATCH_MARGIN  = 1'b0,
    CFG_CHANGE_MARGIN = 1'b1
  } rss_cfg_e;

  // Junction kinds.
  localparam logic [2:0] JK_STRAIGHT = 3'd0;
  localparam logic [2:0] JK_THREE_WAY = 3'd1;
  localparam logic [2:0] JK_END = 3'd2;
  localparam logic [2:0] JK_CORRIDOR = 3'd3;

  // Corridor sides.
  localparam logic [1:0] SIDE_LEFT = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // Entry actions; everything above ACT_TURN_OTHER means go on.
  localparam logic [2:0] ACT_STOP = 3'd0;
  localparam logic [2:0] ACT_TURN_OTHER = 3'd3;

  // One route table word.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] count;
    logic [1:0] side;
    logic [2:0] action;
  } rss_entry_t;

  // One input transaction.
  typedef struct packed {
    rss_req_e   req;
    logic [2:0] kind;
    logic [7:0] count;
    logic [1:0] side;
    logic [2:0] action;
    logic [3:0] shape;    // front, back, left, right from the top bit down
    logic       stop_req;
  } rss_in_t;

  // One non-status result.
  typedef struct packed {
    rss_okind_e kind;
    logic       stop_value;
    logic [1:0] rotate_code;
  } rss_res_t;

  // All results caused by one input transaction; a status result always closes it.
  typedef struct packed {
    logic       r0_v;
    rss_res_t   r0;
    logic       r1_v;
    rss_res_t   r1;
    logic       stopped;
    logic       turning;
    logic [4:0] pos;
    logic       dropped;
  } rss_rec_t;

endpackage

>>> src/rss_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/rss_core.sv
// ----------------------------------------------------------------------------
// Route scenario sequencer core
// Input register, sequencer state and the single-pass update that turns one
// input transaction into a result record.
// ----------------------------------------------------------------------------
module rss_core #(
  parameter int unsigned ROUTE_DEPTH = rss_pkg::RSS_ROUTE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [3:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rss_pkg::rss_in_t               in_item_i,
  output logic                           rec_valid_o,
  input  logic                           rec_ready_i,
  output rss_pkg::rss_rec_t              rec_o,
  output logic                           ram_we_o,
  output logic [$clog2(ROUTE_DEPTH)-1:0] ram_waddr_o,
  output logic [15:0]                    ram_wdata_o,
  output logic [$clog2(ROUTE_DEPTH)-1:0] ram_raddr_o,
  input  logic [15:0]                    ram_rdata_i
);

  import rss_pkg::*;

  localparam int unsigned PW = $clog2(ROUTE_DEPTH + 1);
  localparam int unsigned AW = $clog2(ROUTE_DEPTH);
  localparam int unsigned PWX = (PW > 5) ? PW : 5;
  localparam logic [PW:0] DEPTH_X = (PW + 1)'(ROUTE_DEPTH);

  // Input register.
  logic    in_v_q;
  rss_in_t in_q;
  logic    fire;

  // Sequencer state.
  logic [3:0]    mmargin_q, cmargin_q;
  logic [PW-1:0] ent_q, ent_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    passed_q, passed_d;
  logic [3:0]    mrun_q, mrun_d;
  logic [3:0]    drun_q, drun_d;
  logic [3:0]    prev_q, prev_d;
  logic          stopped_q, stopped_d;
  logic          refresh_q, refresh_d;
  logic          turning_q, turning_d;
  logic          change_q, change_d;

  // Entry at the current position, and a bypass for a write that the
  // look-ahead read misses.
  rss_entry_t cur_q, cur_d;
  logic       byp_hit_q, byp_hit_d;
  rss_entry_t byp_q, byp_d;

  // Working values.
  rss_entry_t  cur_e, nxt_raw, nxt_e, new_e, load_cur;
  logic [PW:0] pos_p1, rd_full;
  logic [3:0]  mrun_inc;
  logic [7:0]  passed_inc;
  logic        full;
  logic [PWX-1:0] pos_x;
  rss_res_t    co_res;
  logic        co_v;
  rss_rec_t    rec;

  // Junction shape test against one entry.
  function automatic logic shape_fits(rss_entry_t e, logic [3:0] s);
    logic f, b, l, r, res;
    f = s[3];
    b = s[2];
    l = s[1];
    r = s[0];
    case (e.kind)
      JK_STRAIGHT:  res = f && b && !l && !r;
      JK_THREE_WAY: res = b && ((f && (l != r)) || (!f && l && r));
      JK_END:       res = !f && b;
      JK_CORRIDOR: begin
        if (e.side == SIDE_LEFT) begin
          res = l;
        end else if (e.side == SIDE_RIGHT) begin
          res = r;
        end else begin
          res = l || r;
        end
      end
      default:      res = 1'b0;
    endcase
    return res;
  endfunction

  assign fire        = in_v_q && rec_ready_i;
  assign in_ready_o  = !in_v_q || rec_ready_i;
  assign rec_valid_o = in_v_q;
  assign rec_o       = rec;

  // Input register; payload carries no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // Current and look-ahead entries; a position past the loaded entries reads
  // as an all-zero entry.
  always_comb begin
    pos_p1  = {1'b0, pos_q} + (PW + 1)'(1);
    cur_e   = (pos_q < ent_q) ? cur_q : '0;
    nxt_raw = byp_hit_q ? byp_q : rss_entry_t'(ram_rdata_i);
    nxt_e   = (pos_p1 < {1'b0, ent_q}) ? nxt_raw : '0;
    new_e   = '{kind: in_q.kind, count: in_q.count, side: in_q.side, action: in_q.action};
    full    = ({1'b0, ent_q} >= DEPTH_X);
    load_cur = (pos_q == ent_q) ? new_e : cur_e;
    mrun_inc   = (mrun_q == 4'hF) ? mrun_q : mrun_q + 4'd1;
    passed_inc = (passed_q == 8'hFF) ? passed_q : passed_q + 8'd1;
  end

  // Single-pass update for one transaction.
  always_comb begin
    ent_d     = ent_q;
    pos_d     = pos_q;
    passed_d  = passed_q;
    mrun_d    = mrun_q;
    drun_d    = drun_q;
    prev_d    = prev_q;
    stopped_d = stopped_q;
    refresh_d = refresh_q;
    turning_d = turning_q;
    change_d  = change_q;
    cur_d     = cur_q;
    ram_we_o  = 1'b0;
    rec       = '0;
    co_v      = 1'b0;
    co_res    = '0;

    if (fire) begin
      unique case (in_q.req)
        REQ_LOAD: begin
          if (full) begin
            rec.dropped = 1'b1;
          end else begin
            ram_we_o = 1'b1;
            ent_d    = ent_q + PW'(1);
            if (pos_q == ent_q) begin
              cur_d = new_e;
            end
            rec.r0_v = 1'b1;
            rec.r0   = '{kind: OK_STOP, stop_value: 1'b0, rotate_code: 2'd0};
            if (new_e.action == ACT_STOP) begin
              // Starting the run: carry out the entry at the current position.
              stopped_d = 1'b1;
              if (load_cur.action == ACT_STOP) begin
                rec.r1_v = 1'b1;
                rec.r1   = '{kind: OK_STOP, stop_value: 1'b1, rotate_code: 2'd0};
              end else begin
                stopped_d = 1'b0;
                change_d  = 1'b0;
                if (load_cur.action <= ACT_TURN_OTHER) begin
                  turning_d = 1'b1;
                  rec.r1_v  = 1'b1;
                  rec.r1    = '{kind: OK_ROTATE, stop_value: 1'b0,
                                rotate_code: load_cur.action[1:0]};
                end
              end
            end else begin
              stopped_d = 1'b1;
              rec.r0.stop_value = 1'b1;
            end
          end
        end

        REQ_SHAPE: begin
          if (!stopped_q) begin
            if (refresh_q) begin
              prev_d    = in_q.shape;
              refresh_d = 1'b0;
            end
            if (!turning_q) begin
              if (change_q) begin
                // Debounced match against the current entry.
                if (!shape_fits(cur_e, in_q.shape)) begin
                  mrun_d = 4'd0;
                end else if (mrun_inc >= mmargin_q) begin
                  mrun_d   = 4'd0;
                  passed_d = passed_inc;
                  change_d = 1'b0;
                  prev_d   = in_q.shape;
                  if (cur_e.count <= passed_inc) begin
                    passed_d = 8'd0;
                    co_v     = 1'b1;
                  end
                end else begin
                  mrun_d = mrun_inc;
                end
              end else begin
                // Debounced detection of a new junction.
                if (in_q.shape == prev_d) begin
                  drun_d = 4'd0;
                end else if (((drun_q == 4'hF) ? drun_q : drun_q + 4'd1) >= cmargin_q) begin
                  drun_d   = 4'd0;
                  prev_d   = in_q.shape;
                  change_d = 1'b1;
                end else begin
                  drun_d = drun_q + 4'd1;
                end
              end
            end
          end
        end

        REQ_TURN: begin
          turning_d = 1'b0;
          co_v      = 1'b1;
        end

        REQ_EXTSTOP: begin
          stopped_d = in_q.stop_req;
        end

        default: ;
      endcase

      // Advance to the next entry and carry it out.
      if (co_v) begin
        if ({1'b0, pos_q} < DEPTH_X) begin
          pos_d = pos_q + PW'(1);
          cur_d = nxt_raw;
        end
        stopped_d = 1'b1;
        if (nxt_e.action == ACT_STOP) begin
          co_res = '{kind: OK_STOP, stop_value: 1'b1, rotate_code: 2'd0};
          rec.r0_v = 1'b1;
        end else begin
          stopped_d = 1'b0;
          change_d  = 1'b0;
          if (nxt_e.action <= ACT_TURN_OTHER) begin
            turning_d = 1'b1;
            co_res    = '{kind: OK_ROTATE, stop_value: 1'b0, rotate_code: nxt_e.action[1:0]};
            rec.r0_v  = 1'b1;
          end
        end
        rec.r0 = co_res;
        if (in_q.req == REQ_TURN) begin
          refresh_d = 1'b1;
          change_d  = 1'b0;
        end
      end
    end

    pos_x       = PWX'(pos_d);
    rec.stopped = stopped_d;
    rec.turning = turning_d;
    rec.pos     = pos_x[4:0];
  end

  // Look-ahead read of the entry after the next position.
  always_comb begin
    rd_full     = {1'b0, pos_d} + (PW + 1)'(1);
    ram_raddr_o = (rd_full < DEPTH_X) ? rd_full[AW-1:0] : '0;
    ram_waddr_o = ent_q[AW-1:0];
    ram_wdata_o = new_e;
    byp_hit_d   = ram_we_o && (rd_full == {1'b0, ent_q});
    byp_d       = new_e;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mmargin_q <= RSS_MARGIN_RESET;
      cmargin_q <= RSS_MARGIN_RESET;
      ent_q     <= '0;
      pos_q     <= '0;
      passed_q  <= '0;
      mrun_q    <= '0;
      drun_q    <= '0;
      prev_q    <= '0;
      stopped_q <= 1'b1;
      refresh_q <= 1'b1;
      turning_q <= 1'b0;
      change_q  <= 1'b0;
      byp_hit_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (rss_cfg_e'(cfg_idx_i))
          CFG_MATCH_MARGIN:  mmargin_q <= cfg_data_i;
          CFG_CHANGE_MARGIN: cmargin_q <= cfg_data_i;
          default: ;
        endcase
      end
      ent_q     <= ent_d;
      pos_q     <= pos_d;
      passed_q  <= passed_d;
      mrun_q    <= mrun_d;
      drun_q    <= drun_d;
      prev_q    <= prev_d;
      stopped_q <= stopped_d;
      refresh_q <= refresh_d;
      turning_q <= turning_d;
      change_q  <= change_d;
      byp_hit_q <= byp_hit_d;
    end
  end

  // Entry copies carry no reset; they are masked until written.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    byp_q <= byp_d;
  end

endmodule

>>> src/rss_out.sv
// ----------------------------------------------------------------------------
// Route scenario sequencer output stage
// Holds one result record and sends its results one transaction at a time.
// ----------------------------------------------------------------------------
module rss_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_valid_i,
  output logic              rec_ready_o,
  input  rss_pkg::rss_rec_t rec_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output rss_pkg::rss_res_t m_res_o,
  output logic              m_last_o,
  output rss_pkg::rss_rec_t m_rec_o
);

  import rss_pkg::*;

  typedef enum logic [1:0] {
    SLOT_R0,
    SLOT_R1,
    SLOT_STAT
  } slot_e;

  logic     rec_v_q;
  rss_rec_t rec_q;
  slot_e    slot_q;
  logic     send;

  assign send        = rec_v_q && m_ready_i;
  assign m_valid_o   = rec_v_q;
  assign m_last_o    = (slot_q == SLOT_STAT);
  assign rec_ready_o = !rec_v_q || (m_ready_i && m_last_o);
  assign m_rec_o     = rec_q;

  // Result currently offered.
  always_comb begin
    unique case (slot_q)
      SLOT_R0:   m_res_o = rec_q.r0;
      SLOT_R1:   m_res_o = rec_q.r1;
      SLOT_STAT: m_res_o = '{kind: OK_STATUS, stop_value: 1'b0, rotate_code: 2'd0};
      default:   m_res_o = '{kind: OK_STATUS, stop_value: 1'b0, rotate_code: 2'd0};
    endcase
  end

  // Record register and slot sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_v_q <= 1'b0;
      slot_q  <= SLOT_STAT;
    end else if (rec_ready_o) begin
      rec_v_q <= rec_valid_i;
      slot_q  <= rec_i.r0_v ? SLOT_R0 : SLOT_STAT;
    end else if (send) begin
      unique case (slot_q)
        SLOT_R0: slot_q <= rec_q.r1_v ? SLOT_R1 : SLOT_STAT;
        default: slot_q <= SLOT_STAT;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_ready_o && rec_valid_i) begin
      rec_q <= rec_i;
    end
  end

endmodule

>>> src/route_scenario_sequencer.sv
// ----------------------------------------------------------------------------
// Route scenario sequencer
// Builds a route table from load transactions and sequences stop and rotate
// commands from debounced junction shapes and turn-finished events.
// ----------------------------------------------------------------------------
// The first result of a transaction is offered once the transaction has passed
//   the core input register and then the output record register.
// Throughput: one transaction per cycle if it yields one result and the output is
//   not stalled; a record of up to three results is held until its last is taken.
// Reset clears all control state and the loaded-entry count; the route table is
//   not cleared, and entries beyond the loaded count read as stop entries.
module route_scenario_sequencer #(
  parameter int unsigned ROUTE_DEPTH = rss_pkg::RSS_ROUTE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // entry_kind[2:0], entry_count[10:3], entry_side[12:11], entry_action[15:13],
  // open_front[16], open_back[17], open_left[18], open_right[19], stop_request[20]
  input  logic [23:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // stop_value[0], rotate_code[2:1], is_stopped[3], is_turning[4],
  // route_position[9:5], load_dropped[10]
  output logic [15:0] m_axis_tdata_o,
  // out_kind[1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  import rss_pkg::*;

  localparam int unsigned AW = $clog2(ROUTE_DEPTH);

  rss_in_t    in_item;
  rss_rec_t   rec, out_rec;
  logic       rec_valid, rec_ready;
  rss_res_t   out_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  // Unpack the input transaction.
  always_comb begin
    in_item.req      = rss_req_e'(s_axis_tuser_i);
    in_item.kind     = s_axis_tdata_i[2:0];
    in_item.count    = s_axis_tdata_i[10:3];
    in_item.side     = s_axis_tdata_i[12:11];
    in_item.action   = s_axis_tdata_i[15:13];
    in_item.shape    = {s_axis_tdata_i[16], s_axis_tdata_i[17],
                        s_axis_tdata_i[18], s_axis_tdata_i[19]};
    in_item.stop_req = s_axis_tdata_i[20];
  end

  rss_ram #(
    .WIDTH(16),
    .DEPTH(ROUTE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rss_core #(
    .ROUTE_DEPTH(ROUTE_DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .rec_valid_o(rec_valid),
    .rec_ready_i(rec_ready),
    .rec_o      (rec),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  rss_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(rec_valid),
    .rec_ready_o(rec_ready),
    .rec_i      (rec),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_res_o    (out_res),
    .m_last_o   (m_axis_tlast_o),
    .m_rec_o    (out_rec)
  );

  // Pack the result transaction.
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tdata_o = {5'b0, out_rec.dropped, out_rec.pos, out_rec.turning,
                           out_rec.stopped, out_res.rotate_code, out_res.stop_value};

endmodule
